/* design/ocd_pkg.sv */
// Shared types, constants and helper functions for the ordered list block.
// No dependencies; used by ocd_cell and ordered_list_conditional_delete.
package ocd_pkg;

    localparam int MaxCap = 256;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [1:0] KIND_LESS    = 2'd0;
    localparam logic [1:0] KIND_EQUAL   = 2'd1;
    localparam logic [1:0] KIND_GREATER = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY
    } ocd_state_t;

    // Per-cell update command for one apply cycle.
    typedef struct packed {
        logic take_left;   // insert: shift towards the back
        logic take_right;  // remove: close the gap if at or after the match
    } cell_cmd_t;

    // Prefix OR, lowest index first: bit i set if any bit 0..i is set.
    function automatic logic [MaxCap-1:0] prefix_or(input logic [MaxCap-1:0] v);
        logic [MaxCap-1:0] acc;
        acc = v;
        for (int s = 1; s < MaxCap; s = s * 2) begin
            acc = acc | (acc << s);
        end
        return acc;
    endfunction

endpackage

/* design/ocd_cell.sv */
// One list position: holds a 32-bit entry and its registered compare result.
// Depends on ocd_pkg for command type and compare codes.
module ocd_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cmp_en,
    input  logic [1:0]             cmp_kind,
    input  logic signed [31:0]     key,
    input  logic [CW-1:0]          count,
    input  ocd_pkg::cell_cmd_t     cmd,
    input  logic                   at_or_after,
    input  logic signed [31:0]     data_left,
    input  logic signed [31:0]     data_right,
    output logic signed [31:0]     data,
    output logic                   match
);
    import ocd_pkg::*;

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic signed [31:0] data_reg, data_next;
    logic               match_reg, match_next;
    logic               hold_ok;
    logic               test;

    assign hold_ok = IDX < count;

    always_comb begin
        case (cmp_kind)
            KIND_LESS:    test = data_reg < key;
            KIND_EQUAL:   test = data_reg == key;
            KIND_GREATER: test = data_reg > key;
            default:      test = 1'b0;
        endcase
    end

    always_comb begin
        match_next = match_reg;
        if (cmp_en) begin
            match_next = hold_ok & test;
        end
    end

    always_comb begin
        data_next = data_reg;
        if (cmd.take_left) begin
            data_next = data_left;
        end else if (cmd.take_right && at_or_after) begin
            data_next = data_right;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

/* design/ordered_list_conditional_delete.sv */
// Ordered list of up to CAPACITY signed 32-bit values, newest at the front,
// built as a row of cells that each hold one entry and pass it to a neighbour.
// Depends on ocd_pkg and ocd_cell.
//
// Each item (insert, query or remove-first-match) gives one result. The item
// is latched at its accepting edge and its result is offered after a compare
// state, in which every cell compares its entry against the key and registers
// the outcome, and an apply state, in which a prefix OR over those outcomes
// picks the frontmost match and the cells shift in one step (all on insert,
// those at or after the match on remove). One item is in flight at a time;
// s_ready is high only while the block is idle, so no new item is taken
// before the last one has passed idle, compare and apply. A finished result
// waits in the output register without blocking acceptance of the next item,
// but that item's apply state holds until the waiting result is taken. No
// clearing pass is needed after reset.
module ordered_list_conditional_delete #(
    parameter int CAPACITY = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [1:0]         s_compare_kind,
    input  logic signed [31:0] s_key,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic               m_overflow,
    output logic [4:0]         m_entry_count,
    output logic               m_is_empty
);
    import ocd_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    ocd_state_t state_reg, state_next;

    logic [1:0]         mode_reg;
    logic [1:0]         kind_reg;
    logic signed [31:0] key_reg;
    logic [CW-1:0]      count_reg, count_next;

    logic               m_valid_reg, m_valid_next;
    logic               hit_reg, hit_next;
    logic               overflow_reg, overflow_next;

    logic               accept;
    logic               cmp_en;
    logic               apply_go;
    logic [1:0]         cmp_kind;

    logic signed [31:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] after_vec;
    logic               any_match;
    logic               full;
    cell_cmd_t          cmd;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_CMP;
            ST_CMP:   state_next = ST_APPLY;
            ST_APPLY: if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Controls
    always_comb begin
        s_ready  = 1'b0;
        cmp_en   = 1'b0;
        apply_go = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_CMP:   cmp_en = 1'b1;
            ST_APPLY: apply_go = !m_valid_reg || m_ready;
            default:  s_ready = 1'b0;
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg <= s_mode;
            kind_reg <= s_compare_kind;
            key_reg  <= s_key;
        end
    end

    // Query always tests for equality
    assign cmp_kind = (mode_reg == MODE_QUERY) ? KIND_EQUAL : kind_reg;

    assign full      = count_reg == CAP_COUNT;
    assign any_match = |match_vec;
    assign after_vec = CAPACITY'(prefix_or(MaxCap'(match_vec)));

    always_comb begin
        cmd.take_left  = apply_go && (mode_reg == MODE_INSERT) && !full;
        cmd.take_right = apply_go && (mode_reg == MODE_REMOVE) && any_match;
    end

    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            logic signed [31:0] left_d;
            logic signed [31:0] right_d;
            if (i == 0) begin : g_head
                assign left_d = key_reg;
            end else begin : g_mid
                assign left_d = cell_data[i-1];
            end
            if (i == CAPACITY - 1) begin : g_tail
                assign right_d = cell_data[i];
            end else begin : g_body
                assign right_d = cell_data[i+1];
            end
            ocd_cell #(
                .INDEX(i),
                .CW   (CW)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmp_en     (cmp_en),
                .cmp_kind   (cmp_kind),
                .key        (key_reg),
                .count      (count_reg),
                .cmd        (cmd),
                .at_or_after(after_vec[i]),
                .data_left  (left_d),
                .data_right (right_d),
                .data       (cell_data[i]),
                .match      (match_vec[i])
            );
        end
    endgenerate

    // Result and count update
    always_comb begin
        count_next    = count_reg;
        m_valid_next  = m_valid_reg;
        hit_next      = hit_reg;
        overflow_next = overflow_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (apply_go) begin
            m_valid_next  = 1'b1;
            hit_next      = 1'b0;
            overflow_next = 1'b0;
            case (mode_reg)
                MODE_INSERT: begin
                    if (full) begin
                        overflow_next = 1'b1;
                    end else begin
                        hit_next   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                MODE_QUERY: begin
                    hit_next = any_match;
                end
                MODE_REMOVE: begin
                    if (any_match) begin
                        hit_next   = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                default: begin
                    hit_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg      <= hit_next;
        overflow_reg <= overflow_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = hit_reg;
    assign m_overflow    = overflow_reg;
    assign m_entry_count = 5'(count_reg);
    assign m_is_empty    = count_reg == '0;

endmodule

/* tb/ordered_list_conditional_delete_tb.sv */
// Self-checking testbench for ordered_list_conditional_delete: directed table, then random items.
// Expected results: table for typed rows, else a local list model. Depends on ocd_pkg and the block's RTL.
`timescale 1ns / 100ps

module ordered_list_conditional_delete_tb;
    import ocd_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 2000;
    localparam int QUIET_ITEMS  = 300;
    localparam int STALL_LIMIT  = 200;
    localparam int DRAIN_CYCLES = 8;

    // Codes the package leaves unnamed; the block must treat them as no-ops.
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic       hit;
        logic       overflow;
        logic [4:0] entry_count;
        logic       is_empty;
    } list_result_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [1:0]         kind;
        logic signed [31:0] key;
        logic [4:0]         reps;
        bit                 typed;
        list_result_t       known;
    } step_row_t;

    localparam list_result_t NO_RESULT = '0;
    localparam int NUM_ROWS = 23;

    // Typed results are read straight off the spec; the rest come from the model.
    localparam step_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{MODE_QUERY,  KIND_EQUAL,   32'sd0,          5'd1,  1'b1, '{1'b0, 1'b0, 5'd0,  1'b1}},
        '{MODE_REMOVE, KIND_EQUAL,   32'sd0,          5'd1,  1'b1, '{1'b0, 1'b0, 5'd0,  1'b1}},
        '{MODE_INSERT, KIND_LESS,    32'sh80000000,   5'd1,  1'b1, '{1'b1, 1'b0, 5'd1,  1'b0}},
        '{MODE_INSERT, KIND_GREATER, 32'sh7fffffff,   5'd1,  1'b1, '{1'b1, 1'b0, 5'd2,  1'b0}},
        '{MODE_QUERY,  KIND_LESS,    32'sh80000000,   5'd1,  1'b1, '{1'b1, 1'b0, 5'd2,  1'b0}},
        '{MODE_QUERY,  KIND_NONE,    32'sd0,          5'd1,  1'b1, '{1'b0, 1'b0, 5'd2,  1'b0}},
        '{MODE_REMOVE, KIND_NONE,    32'sd0,          5'd1,  1'b1, '{1'b0, 1'b0, 5'd2,  1'b0}},
        '{MODE_NONE,   KIND_NONE,    -32'sd1,         5'd1,  1'b1, '{1'b0, 1'b0, 5'd2,  1'b0}},
        '{MODE_REMOVE, KIND_GREATER, 32'sd0,          5'd1,  1'b1, '{1'b1, 1'b0, 5'd1,  1'b0}},
        '{MODE_REMOVE, KIND_LESS,    32'sh80000000,   5'd1,  1'b1, '{1'b0, 1'b0, 5'd1,  1'b0}},
        '{MODE_REMOVE, KIND_GREATER, 32'sh7fffffff,   5'd1,  1'b1, '{1'b0, 1'b0, 5'd1,  1'b0}},
        '{MODE_REMOVE, KIND_EQUAL,   32'sh80000000,   5'd1,  1'b1, '{1'b1, 1'b0, 5'd0,  1'b1}},
        '{MODE_INSERT, KIND_EQUAL,   -32'sd1,         5'd16, 1'b0, NO_RESULT},
        '{MODE_INSERT, KIND_EQUAL,   32'sd99,         5'd1,  1'b1, '{1'b0, 1'b1, 5'd16, 1'b0}},
        '{MODE_QUERY,  KIND_EQUAL,   32'sd14,         5'd1,  1'b0, NO_RESULT},
        '{MODE_REMOVE, KIND_LESS,    32'sd5,          5'd1,  1'b0, NO_RESULT},
        '{MODE_REMOVE, KIND_GREATER, 32'sd0,          5'd1,  1'b0, NO_RESULT},
        '{MODE_REMOVE, KIND_EQUAL,   -32'sd1,         5'd1,  1'b0, NO_RESULT},
        '{MODE_QUERY,  KIND_EQUAL,   -32'sd1,         5'd1,  1'b0, NO_RESULT},
        '{MODE_NONE,   KIND_LESS,    32'sd0,          5'd1,  1'b0, NO_RESULT},
        '{MODE_REMOVE, KIND_NONE,    32'sd3,          5'd1,  1'b0, NO_RESULT},
        '{MODE_INSERT, KIND_LESS,    32'sd7,          5'd1,  1'b0, NO_RESULT},
        '{MODE_REMOVE, KIND_EQUAL,   32'sd7,          5'd1,  1'b0, NO_RESULT}
    };

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [1:0]         s_mode         = MODE_QUERY;
    logic [1:0]         s_compare_kind = KIND_EQUAL;
    logic signed [31:0] s_key          = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic               m_hit;
    logic               m_overflow;
    logic [4:0]         m_entry_count;
    logic               m_is_empty;

    logic signed [31:0] held_values [CAPACITY];
    int                 held_count = 0;
    list_result_t       expected_results [$];
    int                 mismatches = 0;
    bit                 quiet = 1'b0;
    int                 stall_left = 0;

    ordered_list_conditional_delete #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_compare_kind(s_compare_kind),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_overflow    (m_overflow),
        .m_entry_count (m_entry_count),
        .m_is_empty    (m_is_empty)
    );

    always #5 aclk = ~aclk;

    // Apply one operation to the local list and return the result it should give.
    function automatic list_result_t apply_to_list(input logic [1:0] mode,
                                                   input logic [1:0] kind,
                                                   input logic signed [31:0] key);
        list_result_t res;
        int           found;
        bit           match;
        res   = '0;
        found = -1;
        if (mode == MODE_INSERT) begin
            if (held_count < CAPACITY) begin
                for (int i = held_count; i > 0; i--) held_values[i] = held_values[i - 1];
                held_values[0] = key;
                held_count++;
                res.hit = 1'b1;
            end else begin
                res.overflow = 1'b1;
            end
        end else if (mode == MODE_QUERY) begin
            for (int i = 0; i < held_count; i++) begin
                if (held_values[i] == key) res.hit = 1'b1;
            end
        end else if (mode == MODE_REMOVE) begin
            for (int i = 0; i < held_count; i++) begin
                case (kind)
                    KIND_LESS:    match = held_values[i] < key;
                    KIND_EQUAL:   match = held_values[i] == key;
                    KIND_GREATER: match = held_values[i] > key;
                    default:      match = 1'b0;
                endcase
                if (match && found < 0) found = i;
            end
            if (found >= 0) begin
                // close the gap behind the removed entry
                for (int i = found; i < held_count - 1; i++) held_values[i] = held_values[i + 1];
                held_count--;
                res.hit = 1'b1;
            end
        end
        res.entry_count = 5'(held_count);
        res.is_empty    = (held_count == 0);
        return res;
    endfunction

    task automatic send_item(input logic [1:0] mode, input logic [1:0] kind,
                             input logic signed [31:0] key, input bit typed,
                             input list_result_t known);
        list_result_t predicted;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_compare_kind <= kind;
        s_key          <= key;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_to_list(mode, kind, key);
        expected_results.push_back(typed ? known : predicted);
    endtask

    // Mix small values, held values and extremes so that matches are common.
    function automatic logic signed [31:0] pick_key();
        logic signed [31:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2: k = $signed($urandom_range(0, 16)) - 8;
            3, 4, 5: k = (held_count > 0) ? held_values[$urandom_range(0, held_count - 1)]
                                          : $urandom;
            6: begin
                case ($urandom_range(0, 3))
                    0:       k = 32'sh80000000;
                    1:       k = 32'sh7fffffff;
                    2:       k = 32'sd0;
                    default: k = -32'sd1;
                endcase
            end
            default: k = $urandom;
        endcase
        return k;
    endfunction

    // Result side: stall in random bursts until the quiet tail.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result item with no expectation waiting");
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (m_hit !== want.hit) begin
                    $error("hit: expected %0b, got %0b", want.hit, m_hit);
                    mismatches++;
                end
                if (m_overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b", want.overflow, m_overflow);
                    mismatches++;
                end
                if (m_entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count, m_entry_count);
                    mismatches++;
                end
                if (m_is_empty !== want.is_empty) begin
                    $error("is_empty: expected %0b, got %0b", want.is_empty, m_is_empty);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: give up after a long run of cycles with no item moving on either side.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge aresetn);
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int                 ins_pct;
        int                 pick;
        logic [1:0]         mode;
        logic [1:0]         kind;
        step_row_t          row;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_ROWS[n]) begin
            row = DIRECTED_ROWS[n];
            for (int r = 0; r < row.reps; r++) begin
                send_item(row.mode, row.kind, row.key + r, row.typed, row.known);
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            // alternate filling and draining phases so both full and empty lists recur
            ins_pct = ((n / 150) % 2 == 0) ? 60 : 25;
            pick    = $urandom_range(0, 99);
            if (pick < 3) mode = MODE_NONE;
            else if (pick < 3 + ins_pct) mode = MODE_INSERT;
            else if (pick < 23 + ins_pct) mode = MODE_QUERY;
            else mode = MODE_REMOVE;
            kind = ($urandom_range(0, 9) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
            send_item(mode, kind, pick_key(), 1'b0, NO_RESULT);
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
